FILE: sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_H    = 5;
    localparam int unsigned WIN_N    = 16;
    localparam int unsigned NUM_RND  = 80;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned CNT_W    = 64;
    localparam int unsigned RND_W    = 7;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned OP_W     = 2;

    localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
    localparam logic [RND_W-1:0]  RND_LAST  = 7'(NUM_RND - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = 3'(NUM_H - 1);

    localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

endpackage

FILE: sv/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// channel | dir | tdata               | tuser            | tlast
// s_      | in  | [7:0] data_byte     | [1:0] op         | -
// m_      | out | [31:0] digest_word  | [2:0] word_index | last
//
// An absorb is taken in ST_IDLE; the byte that completes a block then runs 80
// rounds on the shared round unit and one fold into the chaining words.
// A first finish shifts in padding one byte per cycle up to the block end and
// runs one or two compressions, then sends five words; a repeated finish only
// sends the words. s_tready is low while padding shifts in, a block compresses
// or words are sent.
// m_ is held by a stalled m_tready. Reset is synchronous, aresetn active low.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                fin_reg, fin_next;
    logic                tail_reg, tail_next;
    logic                pad_reg, pad_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [WORD_W-1:0]   h_reg [NUM_H];
    logic [WORD_W-1:0]   h_next [NUM_H];
    logic [WORD_W-1:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0]   a_next, b_next, c_next, d_next, e_next;
    logic [WORD_W-1:0]   win_reg [WIN_N];
    logic [WORD_W-1:0]   win_next [WIN_N];
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   m_data_reg, m_data_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic                m_last_reg, m_last_next;

    logic                s_fire;
    logic [BYTE_W-1:0]   shift_byte;
    logic                do_shift;
    logic [WORD_W-1:0]   w_mix, w_cur, f_val, k_val, t_val;
    logic [2:0]          len_sel;
    logic [FILL_W-1:0]   fill_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;
    assign fill_inc = fill_reg + 1'b1;
    assign len_sel  = 3'd7 - fill_reg[2:0];

    always_comb begin
        w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_mix = {w_mix[30:0], w_mix[31]};
        w_cur = (rnd_reg < 7'd16) ? win_reg[0] : w_mix;
        if (rnd_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end else if (rnd_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end else if (rnd_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        tail_next    = tail_reg;
        pad_next     = pad_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        h_next       = h_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        win_next     = win_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        shift_byte   = s_tdata;
        do_shift     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_tuser)
                        OP_ABSORB: begin
                            if (!fin_reg) begin
                                do_shift   = 1'b1;
                                count_next = count_reg + CNT_W'(8);
                                pad_next   = 1'b0;
                            end
                        end
                        OP_FINISH: begin
                            idx_next = '0;
                            if (fin_reg) begin
                                state_next = ST_EMIT;
                            end else begin
                                do_shift   = 1'b1;
                                shift_byte = PAD_MARK;
                                pad_next   = 1'b1;
                                tail_next  = (fill_inc != '0) && (fill_inc <= FILL_LEN);
                                state_next = ST_PAD;
                            end
                        end
                        OP_CLEAR: begin
                            h_next     = H_INIT;
                            fill_next  = '0;
                            count_next = '0;
                            fin_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PAD: begin
                do_shift   = 1'b1;
                shift_byte = (tail_reg && fill_reg >= FILL_LEN) ?
                             count_reg[{len_sel, 3'b000} +: 8] : '0;
            end
            ST_ROUND: begin
                e_next = d_reg;
                d_next = c_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                b_next = a_reg;
                a_next = t_val;
                for (int i = 0; i < WIN_N - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WIN_N-1] = w_cur;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (!pad_reg) begin
                    state_next = ST_IDLE;
                end else if (tail_reg) begin
                    fin_next   = 1'b1;
                    pad_next   = 1'b0;
                    state_next = ST_EMIT;
                end else begin
                    tail_next  = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = h_reg[idx_reg];
                    m_idx_next   = idx_reg;
                    m_last_next  = (idx_reg == IDX_LAST);
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_shift) begin
            for (int i = 0; i < WIN_N - 1; i++) begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[WIN_N-1] = {win_reg[WIN_N-1][23:0], shift_byte};
            fill_next = fill_inc;
            if (fill_reg == FILL_LAST) begin
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                e_next     = h_reg[4];
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            count_reg   <= '0;
            fin_reg     <= 1'b0;
            tail_reg    <= 1'b0;
            pad_reg     <= 1'b0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            h_reg       <= H_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            tail_reg    <= tail_next;
            pad_reg     <= pad_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            h_reg       <= h_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        win_reg    <= win_next;
        m_data_reg <= m_data_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

endmodule

FILE: test/sha1_stream_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_test
// Self-checking bench for the SHA-1 stream hasher. Byte streams, finish,
// clear and unused codes go in on the s_ channel; a local SHA-1 predictor
// keeps its own chaining, block and count state and queues the five digest
// words of each finish, which are compared in order against the m_ channel.
// Both sides idle at random, and one phase holds m_tready low long enough
// for the block to stall its input.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_test;
    import sha1s_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 260;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } digest_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] word_index
    logic        m_tlast;

    logic [WORD_W-1:0] chain_h [NUM_H];
    logic [BYTE_W-1:0] blk [64];
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  bit_count;
    logic              done_flag;

    digest_item_t pending_words [$];

    int  mismatch_count;
    int  items_sent;
    int  idle_cycles;
    int  rx_hold;
    int  stall_left;
    bit  tx_gaps_on;
    bit  rx_gaps_on;

    sha1_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void hasher_reset();
        for (int i = 0; i < NUM_H; i++) chain_h[i] = H_INIT[i];
        for (int i = 0; i < 64; i++) blk[i] = '0;
        fill      = '0;
        bit_count = '0;
        done_flag = 1'b0;
    endfunction

    function automatic void hash_block();
        logic [WORD_W-1:0] w [WIN_N];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, t, nw;
        for (int r = 0; r < WIN_N; r++) begin
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < NUM_RND; r++) begin
            if (r < 16) begin
                nw = w[r];
            end else begin
                nw = rotl32(w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15], 1);
                w[r & 15] = nw;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = rotl32(a, 5) + f + e + k + nw;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void pad_and_close();
        int pos;
        pos = int'(fill);
        blk[pos] = PAD_MARK;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                blk[pos] = '0;
                pos++;
            end
            hash_block();
            pos = 0;
        end
        while (pos < 56) begin
            blk[pos] = '0;
            pos++;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = bit_count[63-8*i -: 8];
        hash_block();
        fill = '0;
    endfunction

    function automatic void predict_digest(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] data);
        digest_item_t item;
        case (op)
            OP_ABSORB: begin
                if (!done_flag) begin
                    bit_count += 64'd8;
                    blk[fill] = data;
                    fill = fill + 1'b1;
                    if (fill == '0) hash_block();
                end
            end
            OP_CLEAR: begin
                hasher_reset();
            end
            OP_FINISH: begin
                if (!done_flag) begin
                    pad_and_close();
                    done_flag = 1'b1;
                end
                for (int i = 0; i < NUM_H; i++) begin
                    item.word  = chain_h[i];
                    item.index = IDX_W'(i);
                    item.last  = (i == NUM_H - 1);
                    pending_words.push_back(item);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 55;
            3:       return 56;
            4:       return 57;
            5:       return 63;
            6:       return 64;
            7:       return 65;
            8:       return 119;
            9:       return 120;
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input digest_item_t want,
                                 input digest_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected word %h index %0d last %b,",
                     what, want.word, want.index, want.last);
            $display("    got word %h index %0d last %b", got.word, got.index, got.last);
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) begin
                s_tdata <= BYTE_W'($urandom);
                s_tuser <= OP_W'($urandom);
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predict_digest(op, data);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic test_empty_message();
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_ABSORB, 8'hFF);
        send_item(OP_FINISH, 8'h5A);
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic test_byte_extremes();
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hFF);
        send_item(OP_ABSORB, 8'h80);
        send_item(OP_ABSORB, 8'h7F);
        send_item(OP_ABSORB, 8'h01);
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_CLEAR, 8'hFF);
    endtask

    task automatic test_ignored_items();
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_ABSORB, 8'hA5);
        send_item(OP_UNUSED, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        for (int i = 0; i < 6; i++) send_item(OP_ABSORB, BYTE_W'($urandom));
        rx_hold = 400;
        send_item(OP_FINISH, BYTE_W'($urandom));
        send_item(OP_CLEAR, BYTE_W'($urandom));
        for (int i = 0; i < 4; i++) send_item(OP_ABSORB, BYTE_W'($urandom));
        send_item(OP_FINISH, BYTE_W'($urandom));
        send_item(OP_FINISH, BYTE_W'($urandom));
        send_item(OP_CLEAR, BYTE_W'($urandom));
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_messages();
        int len;
        int useful;
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            len = pick_length();
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, BYTE_W'($urandom));
                send_item(OP_ABSORB, BYTE_W'($urandom));
            end
            useful += len + 2;
            if ($urandom_range(0, 9) == 0) begin
                send_item(OP_CLEAR, BYTE_W'($urandom));
            end else begin
                send_item(OP_FINISH, BYTE_W'($urandom));
                if ($urandom_range(0, 3) == 0) send_item(OP_ABSORB, BYTE_W'($urandom));
                if ($urandom_range(0, 3) == 0) send_item(OP_FINISH, BYTE_W'($urandom));
                send_item(OP_CLEAR, BYTE_W'($urandom));
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                stall_left = rx_hold;
                rx_hold    = 0;
            end
            if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        digest_item_t got;
        digest_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser, m_tlast};
            if (pending_words.size() == 0) begin
                flag_mismatch("no word expected", '0, got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) flag_mismatch("digest word", want, got);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        items_sent     = 0;
        rx_hold        = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        hasher_reset();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_message();
        test_byte_extremes();
        test_ignored_items();
        test_output_backpressure();
        test_random_messages();

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            $display("%0d digest words never arrived", pending_words.size());
            mismatch_count += pending_words.size();
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sha1s_pkg.sv
sv/sha1_stream_hasher.sv
test/sha1_stream_hasher_test.sv
